FILE: rtl/core/trajectory_moving_average_smoother_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory smoother
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_MOVING_AVERAGE_SMOOTHER_UNIT_MACROS_SVH
`define TRAJECTORY_MOVING_AVERAGE_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TMAS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TMAS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tmas_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory smoother package
// Field widths, lane layout and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package tmas_pkg;

  localparam int IN_W      = 24;  // motion field width
  localparam int WORD_W    = 32;  // trajectory word width
  localparam int SUM_W     = 40;  // window sum width
  localparam int RADIUS_W  = 5;
  localparam int NUM_LANES = 3;   // x, y, angle
  localparam int DIV_CNT_W = 6;   // holds SUM_W

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd30;

  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int LANE_ANGLE = 2;

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] lane_word_t;

  typedef struct packed {
    logic signed [IN_W-1:0] motion_x;
    logic signed [IN_W-1:0] motion_y;
    logic signed [IN_W-1:0] motion_angle;
    logic                   final_frame;
  } motion_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] smooth_x;
    logic signed [WORD_W-1:0] smooth_y;
    logic signed [WORD_W-1:0] smooth_angle;
    logic signed [WORD_W-1:0] raw_x;
    logic signed [WORD_W-1:0] raw_y;
    logic signed [WORD_W-1:0] raw_angle;
    logic                     end_of_run;
  } smooth_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/trajectory_moving_average_smoother_unit.sv
// ----------------------------------------------------------------------------
// Trajectory moving-average smoother
// Accumulates per-frame motion into a trajectory, keeps it in a ring memory
// and emits the centered window mean of each frame, cut off at both ends.
//
//   channel  ports                          direction  moves
//   in       in_valid/in_stall/in_data      input      one motion transaction
//   out      out_valid/out_stall/out_data   output     one smoothed result
//   cfg      cfg_wr_en/cfg_wr_data          input      window radius write
//
// An input transaction releases the results that it makes ready, each over a
// window of length W (at most 2R+1); steady state is one result per frame. The
// window sum reads one ring entry per cycle and the mean comes from a 40-step
// bit-serial divider.
// Reset needs no clearing pass: a frame only reads entries of its own run.
// A stalled output holds its register; the next result waits once finished.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trajectory_moving_average_smoother_unit_macros.svh"

module trajectory_moving_average_smoother_unit #(
  parameter int MAX_RADIUS = 31
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  tmas_pkg::motion_t              in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output tmas_pkg::smooth_result_t       out_data,
  input  wire                            cfg_wr_en,
  input  wire [tmas_pkg::RADIUS_W-1:0]   cfg_wr_data
);

  import tmas_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int CW         = $clog2(RING_DEPTH + 1);
  localparam int CW1        = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SUM   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RADIUS_W-1:0]   radius_r, radius_nxt;
  logic [WORD_W-1:0]     accum_r [NUM_LANES];
  logic [WORD_W-1:0]     accum_nxt [NUM_LANES];
  logic [AW-1:0]         newest_r, newest_nxt;
  logic [CW-1:0]         seen_r, seen_nxt;
  logic [CW-1:0]         waiting_r, waiting_nxt;
  logic                  last_r, last_nxt;
  logic [CW-1:0]         emit_age_r, emit_age_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         terms_r, terms_nxt;
  logic [CW-1:0]         rd_age_r, rd_age_nxt;
  logic                  eor_r, eor_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  rd_center_r, rd_center_nxt;
  logic [SUM_W-1:0]      sum_r [NUM_LANES];
  logic [SUM_W-1:0]      sum_nxt [NUM_LANES];
  logic [WORD_W-1:0]     raw_r [NUM_LANES];
  logic [WORD_W-1:0]     raw_nxt [NUM_LANES];
  logic                  neg_r [NUM_LANES];
  logic                  neg_nxt [NUM_LANES];
  logic [SUM_W-1:0]      dvd_r [NUM_LANES];
  logic [SUM_W-1:0]      dvd_nxt [NUM_LANES];
  logic [CW-1:0]         rem_r [NUM_LANES];
  logic [CW-1:0]         rem_nxt [NUM_LANES];
  logic [DIV_CNT_W-1:0]  div_step_r, div_step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  smooth_result_t        out_data_r, out_data_nxt;

  lane_word_t            mem [RING_DEPTH];
  lane_word_t            rdata_r;
  lane_word_t            mem_wdata;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic [IN_W-1:0]       in_lane [NUM_LANES];
  logic [CW-1:0]         r_eff;
  logic [CW-1:0]         age_w, older_w, hi_w, lo_w;
  logic [CW-1:0]         newest_ext;
  logic [CW1-1:0]        slot_wide;
  logic [CW1-1:0]        div_trial [NUM_LANES];
  logic [CW1-1:0]        div_diff [NUM_LANES];
  logic                  div_ge [NUM_LANES];
  logic [WORD_W-1:0]     quot [NUM_LANES];
  logic [WORD_W-1:0]     mean [NUM_LANES];
  logic                  emit_ok;
  logic                  out_load;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [IN_W-1:0]   b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {{(WORD_W - IN_W + 1){b[IN_W-1]}}, b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

  assign in_lane[LANE_X]     = in_data.motion_x;
  assign in_lane[LANE_Y]     = in_data.motion_y;
  assign in_lane[LANE_ANGLE] = in_data.motion_angle;

  // Clamp the programmed radius to what the ring can hold.
  assign r_eff = (radius_r > RADIUS_W'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : CW'(radius_r);

  // Oldest waiting frame and the two halves of its window.
  assign age_w   = waiting_r - 1'b1;
  assign older_w = seen_r - 1'b1 - age_w;
  assign hi_w    = (age_w < r_eff) ? age_w : r_eff;
  assign lo_w    = (older_w < r_eff) ? older_w : r_eff;
  assign emit_ok = (waiting_r != '0) && (last_r || (age_w >= r_eff));

  // Ring slot of a frame by age, age 0 being the newest.
  assign newest_ext = CW'(newest_r);
  assign slot_wide  = (rd_age_r <= newest_ext)
                    ? {1'b0, newest_ext - rd_age_r}
                    : ({1'b0, newest_ext} + CW1'(RING_DEPTH) - {1'b0, rd_age_r});
  assign rd_addr    = slot_wide[AW-1:0];

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // One restoring step per lane: a quotient bit enters at the bottom.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      div_trial[l] = {rem_r[l], dvd_r[l][SUM_W-1]};
      div_diff[l]  = div_trial[l] - {1'b0, cnt_r};
      div_ge[l]    = (div_trial[l] >= {1'b0, cnt_r});
      quot[l]      = dvd_r[l][WORD_W-1:0];
      mean[l]      = neg_r[l] ? (~quot[l] + 1'b1) : quot[l];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = cfg_wr_en ? cfg_wr_data : radius_r;
    newest_nxt    = newest_r;
    seen_nxt      = seen_r;
    waiting_nxt   = waiting_r;
    last_nxt      = last_r;
    emit_age_nxt  = emit_age_r;
    cnt_nxt       = cnt_r;
    terms_nxt     = terms_r;
    rd_age_nxt    = rd_age_r;
    eor_nxt       = eor_r;
    rd_valid_nxt  = 1'b0;
    rd_center_nxt = 1'b0;
    div_step_nxt  = div_step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = newest_r;
    rd_en         = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      accum_nxt[l] = accum_r[l];
      sum_nxt[l]   = sum_r[l];
      raw_nxt[l]   = raw_r[l];
      neg_nxt[l]   = neg_r[l];
      dvd_nxt[l]   = dvd_r[l];
      rem_nxt[l]   = rem_r[l];
      mem_wdata[l] = accum_r[l];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          for (int l = 0; l < NUM_LANES; l++) begin
            accum_nxt[l] = sat_add(accum_r[l], in_lane[l]);
            mem_wdata[l] = accum_nxt[l];
          end
          if (seen_r != '0) begin
            newest_nxt = (newest_r == AW'(RING_DEPTH - 1)) ? '0 : newest_r + 1'b1;
          end
          mem_we      = 1'b1;
          mem_waddr   = newest_nxt;
          seen_nxt    = (seen_r == CW'(RING_DEPTH)) ? seen_r : seen_r + 1'b1;
          waiting_nxt = waiting_r + 1'b1;
          last_nxt    = in_data.final_frame;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (emit_ok) begin
          emit_age_nxt = age_w;
          cnt_nxt      = lo_w + hi_w + 1'b1;
          terms_nxt    = lo_w + hi_w + 1'b1;
          rd_age_nxt   = age_w - hi_w;
          eor_nxt      = last_r && (waiting_r == CW'(1));
          for (int l = 0; l < NUM_LANES; l++) begin
            sum_nxt[l] = '0;
          end
          state_nxt = S_SUM;
        end else begin
          if (last_r) begin
            // Run drained: start a fresh sequence.
            for (int l = 0; l < NUM_LANES; l++) begin
              accum_nxt[l] = '0;
            end
            newest_nxt  = '0;
            seen_nxt    = '0;
            waiting_nxt = '0;
            last_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        if (terms_r != '0) begin
          rd_en         = 1'b1;
          rd_age_nxt    = rd_age_r + 1'b1;
          terms_nxt     = terms_r - 1'b1;
          rd_valid_nxt  = 1'b1;
          rd_center_nxt = (rd_age_r == emit_age_r);
        end
        if (rd_valid_r) begin
          for (int l = 0; l < NUM_LANES; l++) begin
            sum_nxt[l] = sum_r[l] + {{(SUM_W - WORD_W){rdata_r[l][WORD_W-1]}}, rdata_r[l]};
          end
        end
        if (rd_center_r) begin
          for (int l = 0; l < NUM_LANES; l++) begin
            raw_nxt[l] = rdata_r[l];
          end
        end
        if ((terms_r == '0) && !rd_valid_r) begin
          // Divide magnitudes; restore the sign on the quotient.
          for (int l = 0; l < NUM_LANES; l++) begin
            neg_nxt[l] = sum_r[l][SUM_W-1];
            dvd_nxt[l] = sum_r[l][SUM_W-1] ? (~sum_r[l] + 1'b1) : sum_r[l];
            rem_nxt[l] = '0;
          end
          div_step_nxt = DIV_CNT_W'(SUM_W);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_nxt[l] = div_ge[l] ? div_diff[l][CW-1:0] : div_trial[l][CW-1:0];
          dvd_nxt[l] = {dvd_r[l][SUM_W-2:0], div_ge[l]};
        end
        div_step_nxt = div_step_r - 1'b1;
        if (div_step_r == DIV_CNT_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_data_nxt.smooth_x     = mean[LANE_X];
          out_data_nxt.smooth_y     = mean[LANE_Y];
          out_data_nxt.smooth_angle = mean[LANE_ANGLE];
          out_data_nxt.raw_x        = raw_r[LANE_X];
          out_data_nxt.raw_y        = raw_r[LANE_Y];
          out_data_nxt.raw_angle    = raw_r[LANE_ANGLE];
          out_data_nxt.end_of_run   = eor_r;
          out_valid_nxt             = 1'b1;
          waiting_nxt               = waiting_r - 1'b1;
          state_nxt                 = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_RESET;
      newest_r    <= '0;
      seen_r      <= '0;
      waiting_r   <= '0;
      last_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      rd_center_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
        accum_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      newest_r    <= newest_nxt;
      seen_r      <= seen_nxt;
      waiting_r   <= waiting_nxt;
      last_r      <= last_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_center_r <= rd_center_nxt;
      out_valid_r <= out_valid_nxt;
      for (int l = 0; l < NUM_LANES; l++) begin
        accum_r[l] <= accum_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_age_r <= emit_age_nxt;
    cnt_r      <= cnt_nxt;
    terms_r    <= terms_nxt;
    rd_age_r   <= rd_age_nxt;
    eor_r      <= eor_nxt;
    div_step_r <= div_step_nxt;
    out_data_r <= out_data_nxt;
    for (int l = 0; l < NUM_LANES; l++) begin
      sum_r[l] <= sum_nxt[l];
      raw_r[l] <= raw_nxt[l];
      neg_r[l] <= neg_nxt[l];
      dvd_r[l] <= dvd_nxt[l];
      rem_r[l] <= rem_nxt[l];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TMAS_ASSERT_IMP(a_waiting_bound, clk, rst_n, 1'b1, waiting_r <= CW'(MAX_RADIUS + 1), "frames waiting exceed the window")
  `TMAS_ASSERT_IMP(a_divisor_nonzero, clk, rst_n, state_r == S_DIV, cnt_r != '0, "division by an empty window")
  `TMAS_ASSERT_IMP(a_read_in_ring, clk, rst_n, (state_r == S_SUM) && (terms_r != '0), rd_age_r < CW'(RING_DEPTH), "window read beyond ring depth")
  `TMAS_ASSERT_NXT(a_eor_drains, clk, rst_n, out_load && eor_r, waiting_r == '0, "end of run marked with frames still waiting")

endmodule

`default_nettype wire
